// File: sv/cale_pkg.sv
// shared types and codes for the compact array list engine
package cale_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int TYPE_W    = 3;
	localparam int POS_W     = 6;
	localparam int DATA_W    = 32;
	localparam int STAT_W    = 3;

	// request codes
	localparam logic [TYPE_W-1:0] REQ_APPEND   = 3'd0;
	localparam logic [TYPE_W-1:0] REQ_READ_ALL = 3'd1;
	localparam logic [TYPE_W-1:0] REQ_UPDATE   = 3'd2;
	localparam logic [TYPE_W-1:0] REQ_DELETE   = 3'd3;
	localparam logic [TYPE_W-1:0] REQ_SEARCH   = 3'd4;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
	localparam logic [STAT_W-1:0] STAT_FULL     = 3'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd2;
	localparam logic [STAT_W-1:0] STAT_BADIDX   = 3'd3;
	localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd4;

	typedef struct packed {
		logic [TYPE_W-1:0]        req_type;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] data_in;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic [POS_W-1:0]         position_out;
		logic signed [DATA_W-1:0] data_out;
		logic                     last;
	} rsp_t;

	// one read port and one write port into the entry store
	typedef struct packed {
		logic              rd_en;
		logic [POS_W-1:0]  rd_addr;
		logic              wr_en;
		logic [POS_W-1:0]  wr_addr;
		logic [DATA_W-1:0] wr_data;
	} mem_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RA_RD,
		ST_RA_EMIT,
		ST_DEL,
		ST_SRCH,
		ST_RESP
	} state_t;

endpackage

// File: sv/compact_array_list_engine.sv
// top level: packed list of signed words with a count, five request kinds
// append and update write the store from idle, then offer their status; read-all reads
//   and offers each stored word in turn; delete moves each later word down one place
// search reads from entry 0 until a match or the count; one request at a time
// reset: arst_n clears the count, the sequencer and the output valid; the store itself
//   is not cleared, entries at or above the count are never read
module compact_array_list_engine #(
	parameter int DEPTH = cale_pkg::DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  cale_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output cale_pkg::rsp_t rsp
);
	import cale_pkg::*;

	// sequencer to output register
	logic              res_valid;
	logic              res_free;
	rsp_t              res;

	// sequencer to entry store
	mem_req_t          mreq;
	logic [DATA_W-1:0] rdata;

	// output register holding the word being offered
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	cale_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.res_valid(res_valid),
		.res_free (res_free),
		.res      (res),
		.mreq     (mreq),
		.rdata    (rdata)
	);

	cale_ram #(
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.mreq (mreq),
		.rdata(rdata)
	);

	// the register takes a new word when empty or when its word leaves this cycle
	assign res_free = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (res_valid && res_free) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: sv/cale_ram.sv
// entry store: one write port, one read port with registered read data
module cale_ram #(
	parameter int DEPTH = cale_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  cale_pkg::mem_req_t            mreq,
	output logic [cale_pkg::DATA_W-1:0]   rdata
);
	import cale_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (mreq.wr_en) begin
			mem[mreq.wr_addr[AW-1:0]] <= mreq.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (mreq.rd_en) begin
			rdata <= mem[mreq.rd_addr[AW-1:0]];
		end
	end

endmodule

// File: sv/cale_ctrl.sv
// request sequencer: walks the entry store for read-all, delete and search
module cale_ctrl #(
	parameter int DEPTH = cale_pkg::DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  cale_pkg::req_t              req,
	output logic                        res_valid,
	input  logic                        res_free,
	output cale_pkg::rsp_t              res,
	output cale_pkg::mem_req_t          mreq,
	input  logic [cale_pkg::DATA_W-1:0] rdata
);
	import cale_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	state_t            state_q, state_d;
	logic [CW-1:0]     count_q, count_d;
	logic [CW-1:0]     idx_q, idx_d;
	logic [CW-1:0]     idx_s1;
	logic              pend_s1;
	logic              rd_go;
	logic [DATA_W-1:0] key_q;
	rsp_t              res_q, res_d;
	logic              pos_ok;
	logic              ra_last;
	logic              hit;

	assign pos_ok  = {1'b0, req.position} < (POS_W + 1)'(count_q);
	assign ra_last = (idx_q + CW'(1)) == count_q;
	assign hit     = pend_s1 && (rdata == key_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pend_s1 <= rd_go;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		res_q <= res_d;
		if (rd_go) begin
			idx_s1 <= idx_q;
		end
		if (state_q == ST_IDLE && req_valid) begin
			key_q <= req.data_in;
		end
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		res_d     = res_q;
		mreq      = '0;
		rd_go     = 1'b0;
		req_ready = 1'b0;
		res_valid = 1'b0;
		res       = res_q;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					case (req.req_type)
						REQ_APPEND: begin
							state_d = ST_RESP;
							if (count_q == CW'(DEPTH)) begin
								res_d = '{STAT_FULL, '0, '0, 1'b1};
							end else begin
								mreq.wr_en   = 1'b1;
								mreq.wr_addr = POS_W'(count_q);
								mreq.wr_data = req.data_in;
								res_d        = '{STAT_OK, POS_W'(count_q), '0, 1'b1};
								count_d      = count_q + CW'(1);
							end
						end
						REQ_READ_ALL: begin
							if (count_q == '0) begin
								res_d   = '{STAT_EMPTY, '0, '0, 1'b1};
								state_d = ST_RESP;
							end else begin
								idx_d   = '0;
								state_d = ST_RA_RD;
							end
						end
						REQ_UPDATE: begin
							state_d = ST_RESP;
							if (pos_ok) begin
								mreq.wr_en   = 1'b1;
								mreq.wr_addr = req.position;
								mreq.wr_data = req.data_in;
								res_d        = '{STAT_OK, req.position, '0, 1'b1};
							end else begin
								res_d = '{STAT_BADIDX, '0, '0, 1'b1};
							end
						end
						REQ_DELETE: begin
							if (pos_ok) begin
								res_d   = '{STAT_OK, req.position, '0, 1'b1};
								idx_d   = CW'(req.position) + CW'(1);
								state_d = ST_DEL;
							end else begin
								res_d   = '{STAT_BADIDX, '0, '0, 1'b1};
								state_d = ST_RESP;
							end
						end
						REQ_SEARCH: begin
							idx_d   = '0;
							state_d = ST_SRCH;
						end
						default: ;
					endcase
				end
			end
			ST_RA_RD: begin
				mreq.rd_en   = 1'b1;
				mreq.rd_addr = POS_W'(idx_q);
				state_d      = ST_RA_EMIT;
			end
			ST_RA_EMIT: begin
				res_valid = 1'b1;
				res       = '{STAT_OK, POS_W'(idx_q), rdata, ra_last};
				if (res_free) begin
					if (ra_last) begin
						state_d = ST_IDLE;
					end else begin
						idx_d   = idx_q + CW'(1);
						state_d = ST_RA_RD;
					end
				end
			end
			ST_DEL: begin
				// read the next entry while the word read before from entry i+1 lands at i
				rd_go = idx_q < count_q;
				if (rd_go) begin
					mreq.rd_en   = 1'b1;
					mreq.rd_addr = POS_W'(idx_q);
					idx_d        = idx_q + CW'(1);
				end
				if (pend_s1) begin
					mreq.wr_en   = 1'b1;
					mreq.wr_addr = POS_W'(idx_s1 - CW'(1));
					mreq.wr_data = rdata;
				end
				if (!rd_go && !pend_s1) begin
					count_d = count_q - CW'(1);
					state_d = ST_RESP;
				end
			end
			ST_SRCH: begin
				if (hit) begin
					res_d   = '{STAT_OK, POS_W'(idx_s1), '0, 1'b1};
					state_d = ST_RESP;
				end else if (idx_q < count_q) begin
					rd_go        = 1'b1;
					mreq.rd_en   = 1'b1;
					mreq.rd_addr = POS_W'(idx_q);
					idx_d        = idx_q + CW'(1);
				end else if (!pend_s1) begin
					res_d   = '{STAT_NOTFOUND, '0, '0, 1'b1};
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				res_valid = 1'b1;
				if (res_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
